// File: rtl/otsl_pkg.sv
// Package for the overcurrent trip and short locator unit.
// Holds the transfer payload types, the configuration bundle and shared constants.
// No dependencies.
`default_nettype none

package otsl_pkg;

    // Default width of the converter readings used by the filter.
    localparam int SAMPLE_BITS_DEFAULT = 10;

    // Configuration register indexes.
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_HOLD      = 3'd1;
    localparam logic [2:0] CFG_DISPLAY   = 3'd2;
    localparam logic [2:0] CFG_PULSE     = 3'd3;
    localparam logic [2:0] CFG_RESEND    = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  THRESHOLD_RESET = 8'd50;
    localparam logic [15:0] HOLD_RESET      = 16'd10;
    localparam logic [15:0] DISPLAY_RESET   = 16'd100;
    localparam logic [15:0] PULSE_RESET     = 16'd5;
    localparam logic [15:0] RESEND_RESET    = 16'd100;

    // Input command codes.
    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // One input item.
    typedef struct packed {
        logic        command;
        logic [15:0] now;
        logic [9:0]  sample;
        logic [9:0]  test_sample;
        logic        notify;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [2:0] mode;
        logic       emergency;
        logic [1:0] stop_sends;
        logic [1:0] clear_sends;
        logic       rail1_power;
        logic       rail2_power;
        logic [1:0] table_power_path;
        logic [3:0] table_select;
        logic       report_valid;
        logic [3:0] path1_code;
        logic [3:0] path2_code;
    } out_item_t;

    // Current configuration register contents.
    typedef struct packed {
        logic [7:0]  threshold_tenths;
        logic [15:0] hold_ticks;
        logic [15:0] display_ticks;
        logic [15:0] pulse_ticks;
        logic [15:0] resend_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/otsl_cfg.sv
// Configuration register bank of the overcurrent trip and short locator unit.
// Depends on otsl_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module otsl_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output otsl_pkg::cfg_t     cfg,
    output logic               reseed
);
    import otsl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the addressed register; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        reseed   = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:
                begin
                    cfg_next.threshold_tenths = cfg_data[7:0];
                    reseed = 1'b1;
                end
                CFG_HOLD:    cfg_next.hold_ticks    = cfg_data;
                CFG_DISPLAY: cfg_next.display_ticks = cfg_data;
                CFG_PULSE:   cfg_next.pulse_ticks   = cfg_data;
                CFG_RESEND:  cfg_next.resend_ticks  = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_tenths <= THRESHOLD_RESET;
            cfg_reg.hold_ticks       <= HOLD_RESET;
            cfg_reg.display_ticks    <= DISPLAY_RESET;
            cfg_reg.pulse_ticks      <= PULSE_RESET;
            cfg_reg.resend_ticks     <= RESEND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/otsl_core.sv
// Step logic of the overcurrent trip and short locator unit: filter, trip timer,
// short-locating sweep sequencer and their state registers.
// Depends on otsl_pkg for the payload types and cfg_t.
`default_nettype none

module otsl_core #(
    parameter int SAMPLE_BITS = otsl_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  otsl_pkg::in_item_t  item,
    input  otsl_pkg::cfg_t      cfg,
    input  wire logic           reseed,
    output otsl_pkg::out_item_t result
);
    import otsl_pkg::*;

    // Phase codes; the output mode carries them directly.
    localparam logic [2:0] PH_ARMED   = 3'd0;
    localparam logic [2:0] PH_ACTIVE  = 3'd1;
    localparam logic [2:0] PH_START   = 3'd2;
    localparam logic [2:0] PH_PULSE   = 3'd3;
    localparam logic [2:0] PH_LATCHED = 3'd4;

    localparam logic [3:0] SHORT_NONE = 4'd15;
    localparam logic [3:0] CODE_RAIL  = 4'd10;
    localparam logic [3:0] CODE_OK    = 4'd0;
    localparam logic [3:0] BARE_RAIL  = 4'd0;
    localparam logic [1:0] PATH_ONE   = 2'd1;
    localparam logic [1:0] PATH_TWO   = 2'd2;
    localparam logic [1:0] PATH_NONE  = 2'd0;
    localparam logic [3:0] P1_FIRST   = 4'd1;
    localparam logic [3:0] P1_LAST    = 4'd4;
    localparam logic [3:0] P2_FIRST   = 4'd5;
    localparam logic [3:0] P2_LAST    = 4'd9;
    localparam logic [1:0] STOP_TRIP  = 2'd3;
    localparam logic [1:0] STOP_AGAIN = 2'd2;
    localparam logic [1:0] CLEAR_MSGS = 2'd2;

    // Widths for the filter and the level compares.
    localparam int SW  = SAMPLE_BITS;
    localparam int EXT = SAMPLE_BITS + 16;
    localparam int CW  = SAMPLE_BITS + 12;

    // Stored short record of one path mapped to its report code.
    function automatic logic [3:0] code_of(input logic [3:0] v);
        logic [3:0] c;
        begin
            if (v == SHORT_NONE)
                c = CODE_OK;
            else if (v == BARE_RAIL)
                c = CODE_RAIL;
            else
                c = v;
            return c;
        end
    endfunction

    logic [2:0]    phase_reg,       phase_next;
    logic [SW-1:0] avg_reg,         avg_next;
    logic          seeded_reg,      seeded_next;
    logic [15:0]   hold_start_reg,  hold_start_next;
    logic          hold_run_reg,    hold_run_next;
    logic [15:0]   trip_time_reg,   trip_time_next;
    logic [15:0]   resend_time_reg, resend_time_next;
    logic [15:0]   pulse_time_reg,  pulse_time_next;
    logic [1:0]    path_reg,        path_next;
    logic [3:0]    table_reg,       table_next;
    logic [3:0]    short1_reg,      short1_next;
    logic [3:0]    short2_reg,      short2_next;
    logic          alarm_reg,       alarm_next;

    logic [EXT-1:0] sample_wide;
    logic [EXT-1:0] test_wide;
    logic [SW-1:0]  sample_m;
    logic [SW-1:0]  test_m;
    logic [11:0]    hi;
    logic [SW+2:0]  filt_sum;
    logic [SW-1:0]  filt;

    // Reading masks, threshold level and the 7/8 filter term.
    assign sample_wide = EXT'(item.sample);
    assign test_wide   = EXT'(item.test_sample);
    assign sample_m    = sample_wide[SW-1:0];
    assign test_m      = test_wide[SW-1:0];
    assign hi          = {1'b0, cfg.threshold_tenths, 3'b000}
                       + {3'b000, cfg.threshold_tenths, 1'b0};
    assign filt_sum    = {avg_reg, 3'b000} - {3'b000, avg_reg} + {3'b000, sample_m};
    assign filt        = filt_sum[SW+2:3];

    // Next state and result of one step.
    always_comb
    begin
        logic          high;
        logic [15:0]   hs;
        logic [3:0]    cur_short;
        logic [3:0]    new_short;
        logic [3:0]    first_t;
        logic [3:0]    last_t;
        logic          path_done;
        logic [3:0]    s1;
        logic [3:0]    s2;

        phase_next       = phase_reg;
        avg_next         = avg_reg;
        seeded_next      = seeded_reg;
        hold_start_next  = hold_start_reg;
        hold_run_next    = hold_run_reg;
        trip_time_next   = trip_time_reg;
        resend_time_next = resend_time_reg;
        pulse_time_next  = pulse_time_reg;
        path_next        = path_reg;
        table_next       = table_reg;
        short1_next      = short1_reg;
        short2_next      = short2_reg;
        alarm_next       = alarm_reg;
        result           = '0;

        high      = 1'b0;
        hs        = hold_start_reg;
        cur_short = (path_reg == PATH_ONE) ? short1_reg : short2_reg;
        new_short = cur_short;
        first_t   = (path_reg == PATH_ONE) ? P1_FIRST : P2_FIRST;
        last_t    = (path_reg == PATH_ONE) ? P1_LAST : P2_LAST;
        path_done = 1'b0;
        s1        = short1_reg;
        s2        = short2_reg;

        if (step_en)
        begin
            if (item.command == CMD_CLEAR)
            begin
                // A clear resets the emergency unless the block is already idle.
                if (alarm_reg || phase_reg != PH_ARMED)
                begin
                    alarm_next       = 1'b0;
                    hold_run_next    = 1'b0;
                    hold_start_next  = '0;
                    resend_time_next = item.now;
                    trip_time_next   = '0;
                    pulse_time_next  = '0;
                    path_next        = PATH_ONE;
                    table_next       = BARE_RAIL;
                    short1_next      = SHORT_NONE;
                    short2_next      = SHORT_NONE;
                    seeded_next      = 1'b0;
                    phase_next       = PH_ARMED;
                    if (item.notify)
                        result.clear_sends = CLEAR_MSGS;
                end
            end
            else
            begin
                // Filter update, seeded by the first sample.
                avg_next    = seeded_reg ? filt : sample_m;
                seeded_next = 1'b1;
                high        = CW'(avg_next) >= CW'(hi);

                case (phase_reg)
                    PH_ARMED:
                    begin
                        if (high)
                        begin
                            hs              = hold_run_reg ? hold_start_reg : item.now;
                            hold_run_next   = 1'b1;
                            hold_start_next = hs;
                            if (16'(item.now - hs) >= cfg.hold_ticks)
                            begin
                                result.stop_sends = STOP_TRIP;
                                alarm_next        = 1'b1;
                                resend_time_next  = item.now;
                                trip_time_next    = item.now;
                                hold_run_next     = 1'b0;
                                hold_start_next   = '0;
                                phase_next        = PH_ACTIVE;
                            end
                        end
                        else
                        begin
                            hold_run_next   = 1'b0;
                            hold_start_next = '0;
                        end
                    end
                    PH_ACTIVE:
                    begin
                        if (16'(item.now - trip_time_reg) >= cfg.display_ticks)
                        begin
                            path_next   = PATH_ONE;
                            table_next  = BARE_RAIL;
                            short1_next = SHORT_NONE;
                            short2_next = SHORT_NONE;
                            phase_next  = PH_START;
                        end
                    end
                    PH_START:
                    begin
                        pulse_time_next = item.now;
                        phase_next      = PH_PULSE;
                    end
                    PH_PULSE:
                    begin
                        if (16'(item.now - pulse_time_reg) >= cfg.pulse_ticks)
                        begin
                            // Record the first short of this path.
                            if (CW'(test_m) >= CW'(hi) && cur_short == SHORT_NONE)
                                new_short = table_reg;
                            if (path_reg == PATH_ONE)
                                s1 = new_short;
                            else
                                s2 = new_short;
                            short1_next = s1;
                            short2_next = s2;

                            // Step to the next table, or end this path.
                            if (table_reg == BARE_RAIL)
                            begin
                                if (new_short == BARE_RAIL)
                                    path_done = 1'b1;
                                else
                                begin
                                    table_next = first_t;
                                    phase_next = PH_START;
                                end
                            end
                            else if (table_reg < last_t)
                            begin
                                table_next = table_reg + 4'd1;
                                phase_next = PH_START;
                            end
                            else
                                path_done = 1'b1;

                            if (path_done)
                            begin
                                if (path_reg == PATH_ONE)
                                begin
                                    path_next  = PATH_TWO;
                                    table_next = BARE_RAIL;
                                    phase_next = PH_START;
                                end
                                else
                                begin
                                    result.report_valid = 1'b1;
                                    result.path1_code   = code_of(s1);
                                    result.path2_code   = code_of(s2);
                                    resend_time_next    = item.now;
                                    phase_next          = PH_LATCHED;
                                end
                            end
                        end
                    end
                    PH_LATCHED:
                    begin
                        if (high && 16'(item.now - resend_time_reg) >= cfg.resend_ticks)
                        begin
                            result.stop_sends = STOP_AGAIN;
                            resend_time_next  = item.now;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            // Status and power outputs follow the state after the step.
            result.mode      = phase_next;
            result.emergency = alarm_next;
            if (phase_next == PH_PULSE)
            begin
                if (path_next == PATH_ONE)
                    result.rail1_power = 1'b1;
                else
                    result.rail2_power = 1'b1;
                if (table_next != BARE_RAIL)
                begin
                    result.table_power_path = (path_next == PATH_ONE) ? PATH_ONE : PATH_TWO;
                    result.table_select     = table_next;
                end
                else
                    result.table_power_path = PATH_NONE;
            end
        end

        // A threshold write unseeds the filter.
        if (reseed)
            seeded_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_ARMED;
            avg_reg         <= '0;
            seeded_reg      <= 1'b0;
            hold_start_reg  <= '0;
            hold_run_reg    <= 1'b0;
            trip_time_reg   <= '0;
            resend_time_reg <= '0;
            pulse_time_reg  <= '0;
            path_reg        <= PATH_ONE;
            table_reg       <= BARE_RAIL;
            short1_reg      <= SHORT_NONE;
            short2_reg      <= SHORT_NONE;
            alarm_reg       <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            avg_reg         <= avg_next;
            seeded_reg      <= seeded_next;
            hold_start_reg  <= hold_start_next;
            hold_run_reg    <= hold_run_next;
            trip_time_reg   <= trip_time_next;
            resend_time_reg <= resend_time_next;
            pulse_time_reg  <= pulse_time_next;
            path_reg        <= path_next;
            table_reg       <= table_next;
            short1_reg      <= short1_next;
            short2_reg      <= short2_next;
            alarm_reg       <= alarm_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/overcurrent_trip_and_short_locator_unit.sv
// Overcurrent trip and short locator unit, top level.
// An input transfer reaches its result through the input register and the result register.
// Throughput: one item per cycle while out_stall is low; a result stall holds the flow.
// Reset: rst_n clears all control state and restores the configuration defaults at once.
// Depends on otsl_pkg, otsl_cfg and otsl_core.
`default_nettype none

module overcurrent_trip_and_short_locator_unit #(
    parameter int SAMPLE_BITS = otsl_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  otsl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output otsl_pkg::out_item_t out_data,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_data
);
    import otsl_pkg::*;

    in_item_t  in_item_reg;
    logic      in_valid_reg, in_valid_next;
    out_item_t out_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t step_result;
    cfg_t      cfg;
    logic      reseed;
    logic      advance;
    logic      accept;

    // Pipeline control: the held item moves on when the result register is empty or being read.
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign accept         = in_valid && !in_stall;
    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    otsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .reseed    (reseed)
    );

    otsl_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .reseed  (reseed),
        .result  (step_result)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

`default_nettype wire

// File: sim/otsl_checker.sv
// Scoreboard for the overcurrent trip and short locator unit.
// Watches the input, result and configuration ports, predicts each result and compares it.
// Depends on otsl_pkg.
`timescale 1ns / 1ps

module otsl_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_stall,
    input  otsl_pkg::in_item_t  in_data,
    input  wire logic           out_valid,
    input  wire logic           out_stall,
    input  otsl_pkg::out_item_t out_data,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    output int                  failures,
    output int                  pending,
    output int                  checked,
    output int                  trips,
    output int                  reports
);
    import otsl_pkg::*;

    // Phases of the trip and sweep sequence, as reported in the mode field.
    typedef enum logic [2:0] {
        PH_ARMED      = 3'd0,
        PH_ACTIVE     = 3'd1,
        PH_DIAG_START = 3'd2,
        PH_DIAG_PULSE = 3'd3,
        PH_LATCHED    = 3'd4
    } unit_phase_e;

    localparam logic [1:0] PATH_ONE     = 2'd1;
    localparam logic [1:0] PATH_TWO     = 2'd2;
    localparam logic [3:0] PATH1_FIRST  = 4'd1;
    localparam logic [3:0] PATH1_LAST   = 4'd4;
    localparam logic [3:0] PATH2_FIRST  = 4'd5;
    localparam logic [3:0] PATH2_LAST   = 4'd9;
    localparam logic [3:0] HIT_NONE     = 4'd15;
    localparam logic [3:0] HIT_RAIL     = 4'd0;
    localparam logic [3:0] CODE_OK      = 4'd0;
    localparam logic [3:0] CODE_RAIL    = 4'd10;
    localparam logic [1:0] STOPS_ON_TRIP = 2'd3;
    localparam logic [1:0] STOPS_RESEND  = 2'd2;
    localparam logic [1:0] CLEARS_SENT   = 2'd2;

    // Configuration copy.
    logic [7:0]  thr_tenths;
    logic [15:0] hold_len;
    logic [15:0] display_len;
    logic [15:0] pulse_len;
    logic [15:0] resend_len;

    // Predicted unit state.
    unit_phase_e ph;
    logic [9:0]  avg;
    logic        avg_seeded;
    logic [15:0] hold_t0;
    logic        hold_on;
    logic [15:0] trip_t;
    logic [15:0] resend_t;
    logic [15:0] pulse_t;
    logic [1:0]  path;
    logic [3:0]  tbl;
    logic [3:0]  first_hit [2];
    logic        alarm;

    out_item_t expected_results[$];

    initial begin
        failures = 0;
        pending  = 0;
        checked  = 0;
        trips    = 0;
        reports  = 0;
    end

    // Tick difference, modulo the counter width.
    function automatic logic [15:0] ticks_since(logic [15:0] now_t, logic [15:0] mark);
        return now_t - mark;
    endfunction

    function automatic int hit_slot();
        return (path == PATH_ONE) ? 0 : 1;
    endfunction

    function automatic logic [3:0] path_code(logic [3:0] hit);
        if (hit == HIT_NONE)
            return CODE_OK;
        if (hit == HIT_RAIL)
            return CODE_RAIL;
        return hit;
    endfunction

    function automatic void restart_sweep();
        path         = PATH_ONE;
        tbl          = '0;
        first_hit[0] = HIT_NONE;
        first_hit[1] = HIT_NONE;
    endfunction

    // Go on to path two, or close the sweep and issue the report.
    function automatic void finish_path(logic [15:0] now_t, inout out_item_t res);
        if (path == PATH_ONE)
        begin
            path = PATH_TWO;
            tbl  = '0;
            ph   = PH_DIAG_START;
        end
        else
        begin
            res.report_valid = 1'b1;
            res.path1_code   = path_code(first_hit[0]);
            res.path2_code   = path_code(first_hit[1]);
            resend_t         = now_t;
            ph               = PH_LATCHED;
            reports++;
        end
    endfunction

    // Pick the next table of the sweep; a shorted bare rail skips the tables.
    function automatic void sweep_advance(logic [15:0] now_t, inout out_item_t res);
        logic [3:0] first_tbl;
        logic [3:0] last_tbl;
        first_tbl = (path == PATH_ONE) ? PATH1_FIRST : PATH2_FIRST;
        last_tbl  = (path == PATH_ONE) ? PATH1_LAST : PATH2_LAST;
        if (tbl == '0)
        begin
            if (first_hit[hit_slot()] == HIT_RAIL)
                finish_path(now_t, res);
            else
            begin
                tbl = first_tbl;
                ph  = PH_DIAG_START;
            end
        end
        else if (tbl < last_tbl)
        begin
            tbl = tbl + 4'd1;
            ph  = PH_DIAG_START;
        end
        else
            finish_path(now_t, res);
    endfunction

    // Advance the predicted state by one input transfer and return the expected result.
    function automatic out_item_t step_unit(in_item_t item);
        out_item_t   res;
        int          level;
        logic [15:0] now_t;
        res   = '0;
        level = int'(thr_tenths) * 10;
        now_t = item.now;
        if (item.command == CMD_CLEAR)
        begin
            if (alarm || ph != PH_ARMED)
            begin
                alarm      = 1'b0;
                hold_on    = 1'b0;
                hold_t0    = '0;
                resend_t   = now_t;
                trip_t     = '0;
                pulse_t    = '0;
                restart_sweep();
                avg_seeded = 1'b0;
                ph         = PH_ARMED;
                if (item.notify)
                    res.clear_sends = CLEARS_SENT;
            end
        end
        else
        begin
            if (!avg_seeded)
            begin
                avg        = item.sample;
                avg_seeded = 1'b1;
            end
            else
                avg = 10'((int'(avg) * 7 + int'(item.sample)) / 8);

            case (ph)
                PH_ARMED:
                begin
                    if (int'(avg) >= level)
                    begin
                        if (!hold_on)
                        begin
                            hold_on = 1'b1;
                            hold_t0 = now_t;
                        end
                        if (ticks_since(now_t, hold_t0) >= hold_len)
                        begin
                            res.stop_sends = STOPS_ON_TRIP;
                            alarm    = 1'b1;
                            resend_t = now_t;
                            trip_t   = now_t;
                            hold_on  = 1'b0;
                            hold_t0  = '0;
                            ph       = PH_ACTIVE;
                            trips++;
                        end
                    end
                    else
                    begin
                        hold_on = 1'b0;
                        hold_t0 = '0;
                    end
                end
                PH_ACTIVE:
                begin
                    if (ticks_since(now_t, trip_t) >= display_len)
                    begin
                        restart_sweep();
                        ph = PH_DIAG_START;
                    end
                end
                PH_DIAG_START:
                begin
                    pulse_t = now_t;
                    ph      = PH_DIAG_PULSE;
                end
                PH_DIAG_PULSE:
                begin
                    if (ticks_since(now_t, pulse_t) >= pulse_len)
                    begin
                        if (int'(item.test_sample) >= level && first_hit[hit_slot()] == HIT_NONE)
                            first_hit[hit_slot()] = tbl;
                        sweep_advance(now_t, res);
                    end
                end
                PH_LATCHED:
                begin
                    if (int'(avg) >= level && ticks_since(now_t, resend_t) >= resend_len)
                    begin
                        res.stop_sends = STOPS_RESEND;
                        resend_t       = now_t;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.mode      = ph;
        res.emergency = alarm;
        if (ph == PH_DIAG_PULSE)
        begin
            if (path == PATH_ONE)
                res.rail1_power = 1'b1;
            else
                res.rail2_power = 1'b1;
            if (tbl != '0)
            begin
                res.table_power_path = path;
                res.table_select     = tbl;
            end
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want)
        begin
            $error("result field %s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    // Result transfers are compared first, then the input transfer of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            thr_tenths  = THRESHOLD_RESET;
            hold_len    = HOLD_RESET;
            display_len = DISPLAY_RESET;
            pulse_len   = PULSE_RESET;
            resend_len  = RESEND_RESET;
            ph          = PH_ARMED;
            avg         = '0;
            avg_seeded  = 1'b0;
            hold_t0     = '0;
            hold_on     = 1'b0;
            trip_t      = '0;
            resend_t    = '0;
            pulse_t     = '0;
            restart_sweep();
            alarm       = 1'b0;
            expected_results.delete();
            pending     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THRESHOLD:
                    begin
                        thr_tenths = cfg_data[7:0];
                        avg_seeded = 1'b0;
                    end
                    CFG_HOLD:    hold_len    = cfg_data;
                    CFG_DISPLAY: display_len = cfg_data;
                    CFG_PULSE:   pulse_len   = cfg_data;
                    CFG_RESEND:  resend_len  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("mode", 4'(want.mode), 4'(out_data.mode));
                    check_field("emergency", 4'(want.emergency), 4'(out_data.emergency));
                    check_field("stop_sends", 4'(want.stop_sends), 4'(out_data.stop_sends));
                    check_field("clear_sends", 4'(want.clear_sends), 4'(out_data.clear_sends));
                    check_field("rail1_power", 4'(want.rail1_power), 4'(out_data.rail1_power));
                    check_field("rail2_power", 4'(want.rail2_power), 4'(out_data.rail2_power));
                    check_field("table_power_path", 4'(want.table_power_path),
                                4'(out_data.table_power_path));
                    check_field("table_select", want.table_select, out_data.table_select);
                    check_field("report_valid", 4'(want.report_valid),
                                4'(out_data.report_valid));
                    check_field("path1_code", want.path1_code, out_data.path1_code);
                    check_field("path2_code", want.path2_code, out_data.path2_code);
                    checked++;
                end
            end

            if (in_valid && !in_stall)
                expected_results.push_back(step_unit(in_data));

            pending = expected_results.size();
        end
    end

endmodule

// File: sim/testbench.sv
// Top level of the overcurrent trip and short locator unit testbench.
// Drives polls, clears and register writes with random idling; otsl_checker does the comparing.
// Depends on otsl_pkg, otsl_checker and the unit RTL.
`timescale 1ns / 1ps

module testbench;
    import otsl_pkg::*;

    localparam int RESET_CYCLES      = 9;
    localparam int RANDOM_ITEMS      = 1100;
    localparam int MAX_GAP           = 10;
    localparam int HOLD_STALL_CYCLES = 120;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int DRAIN_CYCLES      = 10;
    localparam int SAMPLE_MAX        = 1023;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int failures;
    int pending;
    int checked;
    int trips;
    int reports;

    // Stimulus bookkeeping.
    logic [15:0] tick     = '0;
    logic [7:0]  thr_cur  = THRESHOLD_RESET;
    int          sent     = 0;
    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;

    always #4 clk = ~clk;

    overcurrent_trip_and_short_locator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    otsl_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked),
        .trips     (trips),
        .reports   (reports)
    );

    // One input transfer after a random gap; valid stays high until the next gap.
    task automatic send(logic cmd, logic [9:0] smp, logic [9:0] tst, logic ntf);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, now: tick, sample: smp, test_sample: tst, notify: ntf};
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // Stop offering and wait until every predicted result has been transferred.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            thr_cur = val[7:0];
    endtask

    // A reading above or below the trip level, where the threshold allows one.
    function automatic logic [9:0] level(bit high);
        int hi;
        hi = int'(thr_cur) * 10;
        if (high && hi <= SAMPLE_MAX)
            return 10'($urandom_range(hi, SAMPLE_MAX));
        if (!high && hi > 0)
            return 10'($urandom_range(0, ((hi > SAMPLE_MAX) ? SAMPLE_MAX + 1 : hi) - 1));
        return 10'($urandom);
    endfunction

    // An optional clear followed by polls whose current mostly stays high, so the unit trips
    // and sweeps; short_pct sets how often a test reading looks shorted.
    task automatic run_sequence(int polls, int short_pct, bit clear_first);
        if (clear_first)
            send(CMD_CLEAR, 10'($urandom), 10'($urandom), 1'($urandom));
        repeat (polls)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                tick = 16'($urandom);
                send(1'($urandom), 10'($urandom), 10'($urandom), 1'($urandom));
            end
            else
            begin
                tick += ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
                send(CMD_POLL, level($urandom_range(0, 99) < 85),
                     level($urandom_range(0, 99) < short_pct), 1'($urandom));
            end
        end
    endtask

    // Result side: a random stall before each transfer, or one long hold when asked.
    initial
    begin
        int wait_cycles;
        forever
        begin
            @(negedge clk);
            wait_cycles = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req)
            begin
                wait_cycles = HOLD_STALL_CYCLES;
                hold_req    = 1'b0;
            end
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog on cycles without any transfer or register write.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: timeout after %0d idle cycles", idle_cycles);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int directed_items;
        int phase_no;
        int short_pct;
        logic [7:0]  thr;
        logic [15:0] hold_v;
        logic [15:0] display_v;
        logic [15:0] pulse_v;
        logic [15:0] resend_v;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: an idle clear, a hold that starts at tick zero,
        // a trip, a shorted bare rail on path one, a full table sweep on path two with the
        // first table shorted, a resend while latched, a clear with messages, a wrap.
        send(CMD_CLEAR, '0, '0, 1'b1);
        tick = 16'd0;
        send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
        tick = 16'd9;
        send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
        tick = 16'd10;
        send(CMD_POLL, '0, '0, 1'b0);
        tick = 16'd109;
        send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
        tick = 16'd110;
        send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
        send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
        tick = 16'd115;
        send(CMD_POLL, 10'(SAMPLE_MAX), 10'(SAMPLE_MAX), 1'b0);
        tick = 16'd116;
        send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
        tick = 16'd121;
        send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
        repeat (5)
        begin
            tick += 16'd1;
            send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
            tick += 16'd5;
            send(CMD_POLL, 10'(SAMPLE_MAX), 10'(SAMPLE_MAX), 1'b0);
        end
        tick += 16'd300;
        send(CMD_POLL, 10'(SAMPLE_MAX), '0, 1'b0);
        send(CMD_CLEAR, '0, '0, 1'b1);
        tick = 16'hFFFF;
        send(CMD_POLL, '0, 10'(SAMPLE_MAX), 1'b1);
        directed_items = sent;

        // Random part, in phases with different settings; each phase starts once all results are out.
        phase_no = 0;
        while (sent - directed_items < RANDOM_ITEMS)
        begin
            drain();
            case (phase_no)
                0:
                begin
                    thr = '0; hold_v = '0; display_v = '0; pulse_v = '0; resend_v = '0;
                end
                1:
                begin
                    thr = 8'hFF; hold_v = 16'hFFFF; display_v = 16'hFFFF;
                    pulse_v = 16'hFFFF; resend_v = 16'hFFFF;
                end
                2:
                begin
                    thr = THRESHOLD_RESET; hold_v = HOLD_RESET; display_v = DISPLAY_RESET;
                    pulse_v = PULSE_RESET; resend_v = RESEND_RESET;
                end
                default:
                begin
                    thr       = 8'($urandom_range(5, 60));
                    hold_v    = 16'($urandom_range(0, 20));
                    display_v = 16'($urandom_range(0, 40));
                    pulse_v   = 16'($urandom_range(0, 8));
                    resend_v  = 16'($urandom_range(0, 30));
                end
            endcase
            write_reg(CFG_THRESHOLD, {8'($urandom), thr});
            write_reg(CFG_HOLD, hold_v);
            write_reg(CFG_DISPLAY, display_v);
            write_reg(CFG_PULSE, pulse_v);
            write_reg(CFG_RESEND, resend_v);
            if ($urandom_range(0, 1))
                write_reg(3'(CFG_RESEND + 1 + $urandom_range(0, 2)), 16'($urandom));

            // Let the result side hold off once while polls keep coming.
            if (phase_no == 3)
                hold_req = 1'b1;

            repeat (2)
            begin
                calm = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 3))
                    0: short_pct = 0;
                    1: short_pct = 10;
                    2: short_pct = 30;
                    default: short_pct = 90;
                endcase
                run_sequence($urandom_range(60, 180), short_pct, $urandom_range(0, 3) != 0);
            end
            phase_no++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("testbench: %0d items over %0d setting phases, %0d results compared",
                 sent, phase_no, checked);
        $display("testbench: %0d trips and %0d completed short sweeps predicted", trips, reports);
        if (failures == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/otsl_pkg.sv
rtl/otsl_cfg.sv
rtl/otsl_core.sv
rtl/overcurrent_trip_and_short_locator_unit.sv
sim/otsl_checker.sv
sim/testbench.sv
